// ===== design/fswg_pkg.sv =====
// fswg_pkg: shared types and constants of the four-shape waveform generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fswg_pkg;

	localparam int AMP_W = 15;
	localparam int LEVEL_W = 16;
	localparam int CODE_W = 16;
	localparam int INDEX_W = 7;
	localparam int SINE_W = 17;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] SHAPE_SINE = 2'd0;
	localparam logic [1:0] SHAPE_SQUARE = 2'd1;
	localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
	localparam logic [1:0] SHAPE_SAWTOOTH = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sd32767;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -16'sd32767;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TAYLOR_DENS [6] = '{156, 110, 72, 42, 20, 6};

	typedef struct packed {
		logic [1:0] shape;
		logic [AMP_W-1:0] amplitude;
		logic signed [LEVEL_W-1:0] offset;
	} cfg_t;

endpackage

`default_nettype wire

// ===== design/fswg_if.sv =====
// fswg_req_if / fswg_rsp_if: valid-ready channels of the waveform generator
// depends on fswg_pkg for payload widths
`timescale 1ns / 1ps
`default_nettype none

interface fswg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface fswg_rsp_if;
	import fswg_pkg::*;
	logic valid;
	logic ready;
	logic [INDEX_W-1:0] point_index;
	logic signed [LEVEL_W-1:0] level;
	logic [CODE_W-1:0] dac_code;
	logic period_end;
	logic clipped;

	modport source (output valid, output point_index, output level, output dac_code,
		output period_end, output clipped, input ready);
	modport sink (input valid, input point_index, input level, input dac_code,
		input period_end, input clipped, output ready);
endinterface

`default_nettype wire

// ===== design/four_shape_waveform_generator_unit.sv =====
// Four-shape waveform generator, top level.
// Each request on req (restart bit) yields one response on rsp: phase index,
// saturated level, converter code, period end and clip flags.
// Shape, amplitude and offset are set through the write port (cfg_we,
// cfg_index, cfg_wdata); write them only while no request is in flight.
// A five-stage pipeline (table lookup, amplitude multiply, reciprocal
// multiply, offset and clamp, converter scaling) carries each request to its
// response. Throughput: one request per cycle while rsp is not stalled, set
// by the single pass of each stage.
// Every stage holds its own valid bit, so bubbles close up while rsp is
// stalled; req.ready drops only once all five stages hold a response.
// Reset clears the phase, the registers and all stage valid bits; the first
// response after reset is phase index zero.
// Depends on fswg_pkg, fswg_if, fswg_phase, fswg_scale and fswg_level.
`timescale 1ns / 1ps
`default_nettype none

module four_shape_waveform_generator_unit #(
	parameter int POINTS = 100,
	parameter int CODE_STEPS = 65536
) (
	input wire logic clk,
	input wire logic arst_n,
	fswg_req_if.sink req,
	fswg_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [fswg_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [fswg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fswg_pkg::*;

	localparam int PW = $clog2(POINTS);

	cfg_t cfg_q;

	logic v1;
	logic r1;
	logic [PW-1:0] idx1;
	logic last1;
	logic signed [SINE_W-1:0] sine1;

	logic v3;
	logic r3;
	logic [PW-1:0] idx3;
	logic last3;
	logic neg3;
	logic [15:0] term3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAVE_SHAPE: cfg_q.shape <= cfg_wdata[1:0];
				REG_AMPLITUDE: cfg_q.amplitude <= cfg_wdata[AMP_W-1:0];
				REG_OFFSET: cfg_q.offset <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	fswg_phase #(.POINTS(POINTS), .PW(PW)) u_phase (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.restart(req.restart),
		.out_valid(v1),
		.out_ready(r1),
		.idx(idx1),
		.last(last1),
		.sine(sine1)
	);

	fswg_scale #(.POINTS(POINTS), .PW(PW)) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(v1),
		.in_ready(r1),
		.idx(idx1),
		.last(last1),
		.sine(sine1),
		.out_valid(v3),
		.out_ready(r3),
		.idx_o(idx3),
		.last_o(last3),
		.neg_o(neg3),
		.term_mag(term3)
	);

	fswg_level #(.CODE_STEPS(CODE_STEPS), .PW(PW)) u_level (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(v3),
		.in_ready(r3),
		.idx(idx3),
		.last(last3),
		.neg(neg3),
		.term_mag(term3),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.point_index(rsp.point_index),
		.level(rsp.level),
		.dac_code(rsp.dac_code),
		.period_end(rsp.period_end),
		.clipped(rsp.clipped)
	);

`ifndef ASSERT_OFF
	// a restart request enters stage 1 as phase zero
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.restart |=> v1 && idx1 == '0)
		else $error("restart did not give phase zero");

	// period end marks the last phase index
	a_period_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.period_end |-> rsp.point_index == INDEX_W'(POINTS - 1))
		else $error("period end on wrong index");

	// a clipped response sits at full scale
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.clipped |-> rsp.level == LEVEL_MAX || rsp.level == LEVEL_MIN)
		else $error("clipped level not at full scale");
`endif

endmodule

`default_nettype wire

// ===== design/fswg_phase.sv =====
// fswg_phase: phase counter and registered sine table lookup (stage 1)
// depends on fswg_pkg; table is built at elaboration from the quarter-wave polynomial
`timescale 1ns / 1ps
`default_nettype none

module fswg_phase #(
	parameter int POINTS = 100,
	parameter int PW = $clog2(POINTS)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic restart,
	output logic out_valid,
	input wire logic out_ready,
	output logic [PW-1:0] idx,
	output logic last,
	output logic signed [fswg_pkg::SINE_W-1:0] sine
);
	import fswg_pkg::*;

	typedef logic signed [SINE_W-1:0] sine_rom_t [POINTS];

	function automatic longint quarter_sine(longint r);
		longint theta;
		longint x2;
		longint p;
		longint s;
		theta = (HALF_PI_Q30 * r) / POINTS;
		x2 = (theta * theta) / Q30_ONE;
		p = Q30_ONE;
		for (int k = 0; k < 6; k++) begin
			p = Q30_ONE - ((x2 * p) / Q30_ONE) / TAYLOR_DENS[k];
		end
		s = (theta * p) / Q30_ONE;
		return (s + 16384) / 32768;
	endfunction

	function automatic logic signed [SINE_W-1:0] sine_at(longint i);
		longint q;
		longint quad;
		longint r;
		longint v;
		q = 4 * i;
		quad = q / POINTS;
		r = q % POINTS;
		case (quad % 4)
			0: v = quarter_sine(r);
			1: v = quarter_sine(POINTS - r);
			2: v = -quarter_sine(r);
			default: v = -quarter_sine(POINTS - r);
		endcase
		return SINE_W'(v);
	endfunction

	function automatic sine_rom_t build_rom();
		sine_rom_t t;
		for (int j = 0; j < POINTS; j++) begin
			t[j] = sine_at(longint'(j));
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	logic [PW-1:0] phase_q;
	logic [PW-1:0] idx_cur;
	logic is_last;
	logic v_s1;
	logic [PW-1:0] idx_s1;
	logic last_s1;
	logic signed [SINE_W-1:0] sine_s1;

	assign in_ready = !v_s1 || out_ready;
	assign idx_cur = restart ? '0 : phase_q;
	assign is_last = (idx_cur == PW'(POINTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			phase_q <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (in_valid && in_ready) begin
				phase_q <= is_last ? '0 : idx_cur + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			idx_s1 <= idx_cur;
			last_s1 <= is_last;
			sine_s1 <= SINE_ROM[idx_cur];
		end
	end

	assign out_valid = v_s1;
	assign idx = idx_s1;
	assign last = last_s1;
	assign sine = sine_s1;

endmodule

`default_nettype wire

// ===== design/fswg_scale.sv =====
// fswg_scale: shape factor times amplitude, then rounded division (stages 2 and 3)
// depends on fswg_pkg; division by the period constants is a reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none

module fswg_scale #(
	parameter int POINTS = 100,
	parameter int PW = $clog2(POINTS)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire fswg_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [PW-1:0] idx,
	input wire logic last,
	input wire logic signed [fswg_pkg::SINE_W-1:0] sine,
	output logic out_valid,
	input wire logic out_ready,
	output logic [PW-1:0] idx_o,
	output logic last_o,
	output logic neg_o,
	output logic [15:0] term_mag
);
	import fswg_pkg::*;

	localparam int H = POINTS / 2;
	localparam int IW = PW + 3;
	localparam int MW = AMP_W + 16;
	localparam int NW = 16 + $clog2(POINTS + 1);
	localparam int PRW = 2 * NW + 1;
	localparam int D2H = 2 * H;
	localparam int D2N = 2 * POINTS;
	localparam int LH = $clog2(D2H);
	localparam int LN = $clog2(D2N);
	localparam logic [63:0] MH_FULL = ((64'd1 << (NW + LH)) + 64'(D2H) - 64'd1) / 64'(D2H);
	localparam logic [63:0] MN_FULL = ((64'd1 << (NW + LN)) + 64'(D2N) - 64'd1) / 64'(D2N);
	localparam logic [NW:0] M_H = MH_FULL[NW:0];
	localparam logic [NW:0] M_N = MN_FULL[NW:0];
	localparam logic signed [IW-1:0] H_S = IW'(H);
	localparam logic signed [IW-1:0] N_S = IW'(POINTS);

	logic signed [IW-1:0] ii;
	logic signed [IW-1:0] tri_f;
	logic signed [IW-1:0] saw_f;
	logic neg_next;
	logic [15:0] fmag;

	logic v_s2;
	logic rdy_s2;
	logic [PW-1:0] idx_s2;
	logic last_s2;
	logic neg_s2;
	logic [MW-1:0] mag_s2;

	logic [NW-1:0] x_num;
	logic [NW:0] m_sel;
	logic [PRW-1:0] prod_next;
	logic [15:0] direct_next;

	logic v_s3;
	logic [PW-1:0] idx_s3;
	logic last_s3;
	logic neg_s3;
	logic [PRW-1:0] prod_s3;
	logic [15:0] direct_s3;

	// stage 2: signed shape factor and its magnitude
	assign ii = signed'(IW'(idx));
	assign tri_f = (ii < H_S) ? IW'(2 * ii - H_S) : IW'(3 * H_S - 2 * ii);
	assign saw_f = IW'(2 * ii - N_S);

	always_comb begin
		case (cfg.shape)
			SHAPE_SINE: begin
				neg_next = sine[SINE_W-1];
				fmag = 16'(sine[SINE_W-1] ? -sine : sine);
			end
			SHAPE_SQUARE: begin
				neg_next = (ii < H_S);
				fmag = 16'd1;
			end
			SHAPE_TRIANGLE: begin
				neg_next = tri_f[IW-1];
				fmag = 16'(tri_f[IW-1] ? -tri_f : tri_f);
			end
			default: begin
				neg_next = saw_f[IW-1];
				fmag = 16'(saw_f[IW-1] ? -saw_f : saw_f);
			end
		endcase
	end

	assign rdy_s2 = !v_s2 || !v_s3 || out_ready;
	assign in_ready = rdy_s2;

	// stage 3: rounded quotient, reciprocal multiply for the period divisors
	assign x_num = (cfg.shape == SHAPE_TRIANGLE) ? NW'({mag_s2, 1'b0}) + NW'(H)
		: NW'({mag_s2, 1'b0}) + NW'(POINTS);
	assign m_sel = (cfg.shape == SHAPE_TRIANGLE) ? M_H : M_N;
	assign prod_next = PRW'(x_num) * PRW'(m_sel);
	assign direct_next = (cfg.shape == SHAPE_SINE)
		? 16'(({1'b0, mag_s2} + 32'd16384) >> 15) : mag_s2[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= in_valid;
			end
			if (!v_s3 || out_ready) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s2) begin
			idx_s2 <= idx;
			last_s2 <= last;
			neg_s2 <= neg_next;
			mag_s2 <= MW'(cfg.amplitude) * MW'(fmag);
		end
		if (v_s2 && (!v_s3 || out_ready)) begin
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;
			neg_s3 <= neg_s2;
			prod_s3 <= prod_next;
			direct_s3 <= direct_next;
		end
	end

	always_comb begin
		case (cfg.shape)
			SHAPE_TRIANGLE: term_mag = 16'(prod_s3 >> (NW + LH));
			SHAPE_SAWTOOTH: term_mag = 16'(prod_s3 >> (NW + LN));
			default: term_mag = direct_s3;
		endcase
	end

	assign out_valid = v_s3;
	assign idx_o = idx_s3;
	assign last_o = last_s3;
	assign neg_o = neg_s3;

endmodule

`default_nettype wire

// ===== design/fswg_level.sv =====
// fswg_level: offset, saturation and converter word (stages 4 and 5)
// depends on fswg_pkg; stage 5 is the result register
`timescale 1ns / 1ps
`default_nettype none

module fswg_level #(
	parameter int CODE_STEPS = 65536,
	parameter int PW = 7
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire fswg_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [PW-1:0] idx,
	input wire logic last,
	input wire logic neg,
	input wire logic [15:0] term_mag,
	output logic out_valid,
	input wire logic out_ready,
	output logic [fswg_pkg::INDEX_W-1:0] point_index,
	output logic signed [fswg_pkg::LEVEL_W-1:0] level,
	output logic [fswg_pkg::CODE_W-1:0] dac_code,
	output logic period_end,
	output logic clipped
);
	import fswg_pkg::*;

	localparam int HALF_STEPS = CODE_STEPS / 2;

	logic signed [17:0] term;
	logic signed [17:0] raw;
	logic signed [LEVEL_W-1:0] sat_next;
	logic clip_next;

	logic v_s4;
	logic rdy_s4;
	logic [PW-1:0] idx_s4;
	logic last_s4;
	logic signed [LEVEL_W-1:0] level_s4;
	logic clip_s4;

	logic [14:0] lmag;
	logic [31:0] scaled;
	logic [CODE_W-1:0] code_next;

	logic v_s5;
	logic [INDEX_W-1:0] idx_s5;
	logic last_s5;
	logic signed [LEVEL_W-1:0] level_s5;
	logic [CODE_W-1:0] code_s5;
	logic clip_s5;

	assign term = neg ? -signed'({2'b00, term_mag}) : signed'({2'b00, term_mag});
	assign raw = 18'(cfg.offset) + term;

	always_comb begin
		if (raw > 18'(LEVEL_MAX)) begin
			sat_next = LEVEL_MAX;
			clip_next = 1'b1;
		end else if (raw < 18'(LEVEL_MIN)) begin
			sat_next = LEVEL_MIN;
			clip_next = 1'b1;
		end else begin
			sat_next = LEVEL_W'(raw);
			clip_next = 1'b0;
		end
	end

	assign rdy_s4 = !v_s4 || !v_s5 || out_ready;
	assign in_ready = rdy_s4;

	// negative levels map below mid-scale, others at and above it
	assign lmag = 15'(level_s4[LEVEL_W-1] ? -level_s4 : level_s4);
	assign scaled = (32'(lmag) * 32'(HALF_STEPS)) >> 15;
	assign code_next = level_s4[LEVEL_W-1] ? CODE_W'(scaled)
		: CODE_W'(scaled + 32'(HALF_STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) begin
				v_s4 <= in_valid;
			end
			if (!v_s5 || out_ready) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s4) begin
			idx_s4 <= idx;
			last_s4 <= last;
			level_s4 <= sat_next;
			clip_s4 <= clip_next;
		end
		if (v_s4 && (!v_s5 || out_ready)) begin
			idx_s5 <= INDEX_W'(idx_s4);
			last_s5 <= last_s4;
			level_s5 <= level_s4;
			code_s5 <= code_next;
			clip_s5 <= clip_s4;
		end
	end

	assign out_valid = v_s5;
	assign point_index = idx_s5;
	assign level = level_s5;
	assign dac_code = code_s5;
	assign period_end = last_s5;
	assign clipped = clip_s5;

endmodule

`default_nettype wire

// ===== test/tb_four_shape_waveform_generator_unit.sv =====
// testbench of four_shape_waveform_generator_unit: directed table, then random requests
// under random idling and long output stalls, checked against the table or a predictor
// depends on fswg_pkg, fswg_if and the design top level
`timescale 1ns / 1ps

module tb_four_shape_waveform_generator_unit;
	import fswg_pkg::*;

	localparam int PERIOD = 4;
	localparam int POINTS = 100;
	localparam int CODE_STEPS = 65536;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 14;
	localparam int PER_PHASE = 125;
	localparam int HOLD_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [INDEX_W-1:0] point_index;
		logic signed [LEVEL_W-1:0] level;
		logic [CODE_W-1:0] dac_code;
		logic period_end;
		logic clipped;
	} sample_t;

	typedef struct packed {
		bit write_cfg;
		logic [1:0] shape;
		logic [AMP_W-1:0] amp;
		logic signed [LEVEL_W-1:0] ofs;
		logic restart;
		bit typed;
		sample_t want;
	} row_t;

	localparam sample_t NO_SAMPLE = '0;
	localparam int N_ROWS = 20;
	localparam row_t DIRECTED [N_ROWS] = '{
		'{1'b0, SHAPE_SINE, 15'd0, 16'sd0, 1'b0, 1'b1,
			'{7'd0, 16'sd0, 16'd32768, 1'b0, 1'b0}},
		'{1'b1, SHAPE_SINE, 15'd32767, 16'sd0, 1'b1, 1'b1,
			'{7'd0, 16'sd0, 16'd32768, 1'b0, 1'b0}},
		'{1'b0, SHAPE_SINE, 15'd0, 16'sd0, 1'b0, 1'b0, NO_SAMPLE},
		'{1'b0, SHAPE_SINE, 15'd0, 16'sd0, 1'b0, 1'b0, NO_SAMPLE},
		'{1'b1, SHAPE_SQUARE, 15'd32767, -16'sd32768, 1'b1, 1'b1,
			'{7'd0, -16'sd32767, 16'd32767, 1'b0, 1'b1}},
		'{1'b1, SHAPE_SQUARE, 15'd32767, 16'sd32767, 1'b1, 1'b1,
			'{7'd0, 16'sd0, 16'd32768, 1'b0, 1'b0}},
		'{1'b1, SHAPE_SQUARE, 15'd0, -16'sd32768, 1'b1, 1'b1,
			'{7'd0, -16'sd32767, 16'd32767, 1'b0, 1'b1}},
		'{1'b1, SHAPE_SINE, 15'd0, 16'sd32767, 1'b1, 1'b1,
			'{7'd0, 16'sd32767, 16'd65535, 1'b0, 1'b0}},
		'{1'b1, SHAPE_SINE, 15'd0, -16'sd32767, 1'b0, 1'b1,
			'{7'd1, -16'sd32767, 16'd32767, 1'b0, 1'b0}},
		'{1'b1, SHAPE_SAWTOOTH, 15'd32767, 16'sd0, 1'b1, 1'b1,
			'{7'd0, -16'sd32767, 16'd32767, 1'b0, 1'b0}},
		'{1'b0, SHAPE_SINE, 15'd0, 16'sd0, 1'b0, 1'b0, NO_SAMPLE},
		'{1'b1, SHAPE_TRIANGLE, 15'd32767, 16'sd0, 1'b1, 1'b1,
			'{7'd0, -16'sd32767, 16'd32767, 1'b0, 1'b0}},
		'{1'b0, SHAPE_SINE, 15'd0, 16'sd0, 1'b0, 1'b0, NO_SAMPLE},
		'{1'b1, SHAPE_SAWTOOTH, 15'd32767, -16'sd32768, 1'b1, 1'b1,
			'{7'd0, -16'sd32767, 16'd32767, 1'b0, 1'b1}},
		'{1'b1, SHAPE_TRIANGLE, 15'd12345, -16'sd1, 1'b0, 1'b0, NO_SAMPLE},
		'{1'b1, SHAPE_SINE, 15'd32767, 16'sd16384, 1'b0, 1'b0, NO_SAMPLE},
		'{1'b1, SHAPE_SQUARE, 15'd1, -16'sd1, 1'b1, 1'b1,
			'{7'd0, -16'sd2, 16'd2, 1'b0, 1'b0}},
		'{1'b1, SHAPE_SINE, 15'd32767, -16'sd32768, 1'b0, 1'b0, NO_SAMPLE},
		'{1'b1, SHAPE_SQUARE, 15'd32767, 16'sd1, 1'b1, 1'b1,
			'{7'd0, -16'sd32766, 16'd32766, 1'b0, 1'b0}},
		'{1'b1, SHAPE_SAWTOOTH, 15'd20000, 16'sd5000, 1'b0, 1'b0, NO_SAMPLE}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fswg_req_if req_ch ();
	fswg_rsp_if rsp_ch ();

	four_shape_waveform_generator_unit #(
		.POINTS(POINTS),
		.CODE_STEPS(CODE_STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of registers and phase
	logic [1:0] gen_shape;
	logic [AMP_W-1:0] gen_amp;
	logic signed [LEVEL_W-1:0] gen_ofs;
	int unsigned gen_phase;

	sample_t pending_samples [$];
	bit typed_pending;
	sample_t typed_sample;
	bit steady;
	bit hold_trigger;
	int mismatches;
	int checked;
	int settings_used;
	int cycles;

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles,
				pending_samples.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic longint round_nearest(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	// sine table entry in Q15, quarter wave from a Q30 Taylor series
	function automatic longint sine_q15(input int unsigned idx);
		int unsigned quad;
		int unsigned r;
		longint theta;
		longint x2;
		longint p;
		longint s;
		longint q15;
		int k;
		quad = (4 * idx) / POINTS;
		r = (4 * idx) % POINTS;
		if (quad[0])
			r = POINTS - r;
		theta = (HALF_PI_Q30 * longint'(r)) / POINTS;
		x2 = (theta * theta) / Q30_ONE;
		p = Q30_ONE;
		for (k = 0; k < 6; k++)
			p = Q30_ONE - ((x2 * p) / Q30_ONE) / TAYLOR_DENS[k];
		s = (theta * p) / Q30_ONE;
		q15 = (s + 16384) / 32768;
		return quad[1] ? -q15 : q15;
	endfunction

	function automatic sample_t predict_sample(input logic restart);
		int unsigned idx;
		longint a;
		longint h;
		longint ii;
		longint term;
		longint lvl;
		longint code;
		sample_t s;
		idx = restart ? 0 : gen_phase;
		a = longint'(gen_amp);
		h = POINTS / 2;
		ii = longint'(idx);
		case (gen_shape)
			SHAPE_SINE: term = round_nearest(a * sine_q15(idx), 32768);
			SHAPE_SQUARE: term = (ii < h) ? -a : a;
			SHAPE_TRIANGLE: begin
				term = (ii < h) ? round_nearest(a * (2 * ii - h), h)
					: round_nearest(a * (3 * h - 2 * ii), h);
			end
			default: term = round_nearest(a * (2 * ii - POINTS), POINTS);
		endcase
		lvl = longint'(gen_ofs) + term;
		s.clipped = 1'b0;
		if (lvl > 32767) begin
			lvl = 32767;
			s.clipped = 1'b1;
		end
		if (lvl < -32767) begin
			lvl = -32767;
			s.clipped = 1'b1;
		end
		if (lvl < 0)
			code = (-lvl * (CODE_STEPS / 2)) / 32768;
		else
			code = (lvl * (CODE_STEPS / 2)) / 32768 + CODE_STEPS / 2;
		s.point_index = idx[INDEX_W-1:0];
		s.level = lvl[LEVEL_W-1:0];
		s.dac_code = code[CODE_W-1:0];
		s.period_end = (idx == POINTS - 1);
		gen_phase = (idx + 1 >= POINTS) ? 0 : idx + 1;
		return s;
	endfunction

	// request side predicts, response side checks, both from pre-edge values
	always @(negedge clk) begin
		sample_t want;
		sample_t got;
		if (arst_n === 1'b1) begin
			if (req_ch.valid && req_ch.ready) begin
				want = predict_sample(req_ch.restart);
				pending_samples.push_back(typed_pending ? typed_sample : want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.point_index, rsp_ch.level, rsp_ch.dac_code,
					rsp_ch.period_end, rsp_ch.clipped};
				if (pending_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response: idx %0d level %0d code %0d",
							got.point_index, got.level, got.dac_code);
				end else begin
					want = pending_samples.pop_front();
					checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"response %0d mismatch: expected idx %0d level %0d ",
								"code %0d end %0b clip %0b, got idx %0d level %0d code %0d ",
								"end %0b clip %0b"}, checked,
								want.point_index, want.level, want.dac_code,
								want.period_end, want.clipped,
								got.point_index, got.level, got.dac_code,
								got.period_end, got.clipped);
					end
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_trigger) begin
				hold_left = HOLD_CYCLES;
				hold_trigger = 1'b0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 11);
			end
		end
	end

	task automatic send_request(input logic restart);
		bit taken;
		while (!steady && $urandom_range(99) < 11) begin
			req_ch.valid <= 1'b0;
			req_ch.restart <= $urandom_range(1);
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_WAVE_SHAPE: gen_shape = data[1:0];
			REG_AMPLITUDE: gen_amp = data[AMP_W-1:0];
			REG_OFFSET: gen_ofs = data;
			default: ;
		endcase
	endtask

	// drain responses, then rewrite registers; junk sets unused bits and writes REG_UNUSED
	task automatic apply_settings(input logic [1:0] shape, input logic [AMP_W-1:0] amp,
		input logic signed [LEVEL_W-1:0] ofs, input bit junk);
		logic [CFG_DATA_W-1:0] noise;
		req_ch.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		noise = junk ? CFG_DATA_W'($urandom) : '0;
		write_reg(REG_WAVE_SHAPE, {noise[CFG_DATA_W-1:2], shape});
		write_reg(REG_AMPLITUDE, {noise[CFG_DATA_W-1], amp});
		write_reg(REG_OFFSET, ofs);
		if (junk)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [1:0] shape;
		logic [AMP_W-1:0] amp;
		logic signed [LEVEL_W-1:0] ofs;
		int ph;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.restart = 1'b0;
		gen_shape = SHAPE_SINE;
		gen_amp = '0;
		gen_ofs = '0;
		gen_phase = 0;
		typed_pending = 1'b0;
		typed_sample = '0;
		steady = 1'b0;
		hold_trigger = 1'b0;
		mismatches = 0;
		checked = 0;
		settings_used = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[n]) begin
			if (DIRECTED[n].write_cfg)
				apply_settings(DIRECTED[n].shape, DIRECTED[n].amp, DIRECTED[n].ofs, 1'b0);
			typed_pending = DIRECTED[n].typed;
			typed_sample = DIRECTED[n].want;
			send_request(DIRECTED[n].restart);
		end
		typed_pending = 1'b0;

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			shape = (ph < 8) ? ph[1:0] : 2'($urandom_range(3));
			case ($urandom_range(3))
				0: amp = '0;
				1: amp = 15'd32767;
				2: amp = AMP_W'($urandom_range(300));
				default: amp = AMP_W'($urandom);
			endcase
			case ($urandom_range(3))
				0: ofs = -16'sd32768;
				1: ofs = 16'sd32767;
				2: ofs = '0;
				default: ofs = LEVEL_W'($urandom);
			endcase
			// full-scale corners first
			if (ph < 4) begin
				amp = 15'd32767;
				ofs = ph[0] ? 16'sd32767 : -16'sd32768;
			end
			steady = (ph == 2);
			apply_settings(shape, amp, ofs, ph % 3 == 1);
			if (ph == 5 || ph == 11)
				hold_trigger = 1'b1;
			repeat (PER_PHASE)
				send_request($urandom_range(99) < 4);
		end

		req_ch.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		mismatches += pending_samples.size();
		$display("%0d responses checked over %0d register settings of all four shapes,",
			checked, settings_used);
		$display("with restarts, clipping at both rails and a long output stall");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
